@@ rtl/vtm_pkg.sv @@
// Shared types, codes and channel widths for the virtual timer multiplexer.
`default_nettype none
package vtm_pkg;

  localparam int OP_W     = 2;
  localparam int IVL_W    = 32;
  localparam int SEL_W    = 3;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 3;
  localparam int MASK_W   = 8;
  localparam int NOW_W    = 32;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - (STATUS_W + ID_W + MASK_W + NOW_W);

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
  } vtm_cmd_t;

  typedef struct packed {
    logic out_free;
  } vtm_sts_t;

endpackage
`default_nettype wire

@@ rtl/vtm_ctrl.sv @@
// Controller: request handshake and sequencing of capture and execute.
`default_nettype none
module vtm_ctrl
  import vtm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire vtm_sts_t sts,
  output vtm_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   rdy_r, rdy_nxt;

  assign in_tready   = rdy_r;
  assign cmd.capture = in_tvalid && rdy_r;
  assign cmd.exec    = (state_r == S_EXEC) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    rdy_nxt   = rdy_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
          rdy_nxt   = 1'b0;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_nxt = S_IDLE;
          rdy_nxt   = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        rdy_nxt   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdy_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rdy_r |-> (state_r == S_IDLE))
    else $error("ready raised outside idle");

endmodule
`default_nettype wire

@@ rtl/vtm_dp.sv @@
// Datapath: request register, counter, slot table with parallel compare, result register.
`default_nettype none
module vtm_dp
  import vtm_pkg::*;
#(
  parameter int NUM_SLOTS  = 8,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire vtm_cmd_t              cmd,
  output vtm_sts_t                   sts,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [IVL_W-1:0]      in_interval,
  input  wire logic                  in_repeat,
  input  wire logic [SEL_W-1:0]      in_sel,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int TW  = (COUNT_BITS > NOW_W) ? COUNT_BITS : NOW_W;
  localparam int IW  = (COUNT_BITS > IVL_W) ? COUNT_BITS : IVL_W;
  localparam int FW  = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;
  localparam int IDW = (NUM_SLOTS > 8) ? $clog2(NUM_SLOTS) : ID_W;

  logic [OP_W-1:0]       op_r;
  logic [IVL_W-1:0]      ivl_r;
  logic                  rep_r;
  logic [SEL_W-1:0]      sel_r;

  logic [COUNT_BITS-1:0] time_r, time_nxt;
  logic [COUNT_BITS-1:0] exp_r [NUM_SLOTS];
  logic [COUNT_BITS-1:0] exp_nxt [NUM_SLOTS];
  logic [COUNT_BITS-1:0] per_r [NUM_SLOTS];
  logic [COUNT_BITS-1:0] per_nxt [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  act_r, act_nxt;
  logic [NUM_SLOTS-1:0]  prd_r, prd_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [MASK_W-1:0]     fired_r, fired_nxt;
  logic [NOW_W-1:0]      now_r, now_nxt;

  logic [COUNT_BITS-1:0] time_inc;
  logic [COUNT_BITS-1:0] ivl_c;
  logic [IW-1:0]         ivl_ext;
  logic [TW-1:0]         time_ext;
  logic [FW-1:0]         fired_ext;
  logic [NUM_SLOTS-1:0]  match;
  logic [NUM_SLOTS-1:0]  free_vec;
  logic [NUM_SLOTS-1:0]  grant;
  logic [NUM_SLOTS-1:0]  sel_hit;
  logic [IDW-1:0]        found;
  logic                  full;

  assign time_inc = time_r + 1'b1;
  assign ivl_ext  = IW'(ivl_r);
  assign ivl_c    = ivl_ext[COUNT_BITS-1:0];
  assign free_vec = ~act_r;
  assign grant    = free_vec & (~free_vec + 1'b1);
  assign full     = &act_r;

  always_comb begin
    found = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match[i]   = act_r[i] && (exp_r[i] == time_inc);
      sel_hit[i] = act_r[i] && ({{(32-SEL_W){1'b0}}, sel_r} == 32'(i));
      if (grant[i]) begin
        found = found | IDW'(i);
      end
    end
  end

  always_comb begin
    time_nxt      = time_r;
    act_nxt       = act_r;
    prd_nxt       = prd_r;
    exp_nxt       = exp_r;
    per_nxt       = per_r;
    status_nxt    = status_r;
    id_nxt        = id_r;
    fired_nxt     = fired_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r && !out_tready;
    fired_ext     = '0;
    time_ext      = '0;
    if (cmd.exec) begin
      status_nxt = ST_OK;
      id_nxt     = '0;
      case (op_r)
        OP_TICK: begin
          time_nxt  = time_inc;
          fired_ext = FW'(match);
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (match[i]) begin
              if (prd_r[i]) begin
                exp_nxt[i] = exp_r[i] + per_r[i];
              end else begin
                act_nxt[i] = 1'b0;
              end
            end
          end
        end
        OP_START: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            id_nxt = found[ID_W-1:0];
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (grant[i]) begin
                act_nxt[i] = 1'b1;
                prd_nxt[i] = rep_r;
                per_nxt[i] = ivl_c;
                exp_nxt[i] = time_r + ivl_c;
              end
            end
          end
        end
        OP_CANCEL: begin
          if (|sel_hit) begin
            act_nxt = act_r & ~sel_hit;
            prd_nxt = prd_r & ~sel_hit;
          end else begin
            status_nxt = ST_NOT_ACTIVE;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
      time_ext      = TW'(time_nxt);
      fired_nxt     = fired_ext[MASK_W-1:0];
      now_nxt       = time_ext[NOW_W-1:0];
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      act_r       <= '0;
      prd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      time_r      <= time_nxt;
      act_r       <= act_nxt;
      prd_r       <= prd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      ivl_r <= in_interval;
      rep_r <= in_repeat;
      sel_r <= in_sel;
    end
    exp_r    <= exp_nxt;
    per_r    <= per_nxt;
    status_r <= status_nxt;
    id_r     <= id_nxt;
    fired_r  <= fired_nxt;
    now_r    <= now_nxt;
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{OUT_PAD_W{1'b0}}, now_r, fired_r, id_r, status_r};

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == OP_TICK) |=> (time_r == COUNT_BITS'($past(time_r) + 1'b1)))
    else $error("counter did not advance on tick");

  a_no_exec_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(time_r) && $stable(act_r))
    else $error("slot state changed without execute");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.exec))
    else $error("result raised without execute");

  a_cancel_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == OP_CANCEL) |=> ((act_r & ~$past(act_r)) == '0))
    else $error("cancel activated a slot");

endmodule
`default_nettype wire

@@ rtl/virtual_timer_multiplexer.sv @@
// Top level: virtual timers sharing one microsecond counter that advances on each tick request.
//
//   channel   ports                          payload, lowest bit first
//   request   in_tvalid/in_tready            tuser: operation; tdata: interval,
//                                            repeat_flag, slot_select
//   result    out_tvalid/out_tready          tdata: status, slot_id, fired_mask,
//                                            now_count
//
// Each request is first captured into the request register, then executed against
// the slot table, whose compare across all slots runs in parallel.
// A new request is taken while the previous result still waits on the output
// register; execution holds until that register is free.
// Reset clears the counter, all active and repeat bits and the output valid.
`default_nettype none
module virtual_timer_multiplexer
  import vtm_pkg::*;
#(
  parameter int NUM_SLOTS  = 8,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // interval, repeat_flag, slot_select
  input  wire logic [OP_W-1:0]       in_tuser,   // operation
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // status, slot_id, fired_mask, now_count
);

  vtm_cmd_t cmd;
  vtm_sts_t sts;

  vtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vtm_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_tuser),
    .in_interval (in_tdata[IVL_W-1:0]),
    .in_repeat   (in_tdata[IVL_W]),
    .in_sel      (in_tdata[IVL_W+SEL_W:IVL_W+1]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

@@ test/timer_table_checker.sv @@
// Checker for the virtual timer multiplexer: predicts each result and compares it.
module timer_table_checker
  import vtm_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     slot_id;
    logic [MASK_W-1:0]   fired;
    logic [NOW_W-1:0]    now;
  } timer_result_t;

  logic [NOW_W-1:0] tick_count;
  logic [NOW_W-1:0] due_at [SLOTS];
  logic [NOW_W-1:0] reload [SLOTS];
  logic [SLOTS-1:0] periodic;
  logic [SLOTS-1:0] armed;

  timer_result_t expected_results [$];
  timer_result_t want;
  timer_result_t got;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic timer_result_t predict_request(logic [OP_W-1:0] op,
                                                    logic [IVL_W-1:0] ivl,
                                                    logic rep,
                                                    logic [SEL_W-1:0] sel);
    timer_result_t r;
    int free_slot;
    r = '0;
    free_slot = -1;
    case (op)
      OP_TICK: begin
        tick_count = tick_count + 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (armed[i] && due_at[i] == tick_count) begin
            r.fired[i] = 1'b1;
            if (periodic[i]) begin
              due_at[i] = due_at[i] + reload[i];
            end else begin
              armed[i] = 1'b0;
            end
          end
        end
      end
      OP_START: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!armed[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          armed[free_slot]    = 1'b1;
          periodic[free_slot] = rep;
          reload[free_slot]   = ivl;
          due_at[free_slot]   = tick_count + ivl;
          r.slot_id           = free_slot[ID_W-1:0];
        end
      end
      OP_CANCEL: begin
        if (sel < SLOTS && armed[sel]) begin
          armed[sel]    = 1'b0;
          periodic[sel] = 1'b0;
        end else begin
          r.status = ST_NOT_ACTIVE;
        end
      end
      default: ;
    endcase
    r.now = tick_count;
    return r;
  endfunction

  task automatic report_field(string name, logic [NOW_W-1:0] expected_val,
                              logic [NOW_W-1:0] actual_val);
    if (expected_val !== actual_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
               expected_val, actual_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_count = '0;
      armed      = '0;
      periodic   = '0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_request(in_tuser, in_tdata[IVL_W-1:0],
                                                   in_tdata[IVL_W],
                                                   in_tdata[IVL_W+1 +: SEL_W]));
      end
      if (out_tvalid && out_tready) begin
        got.status  = out_tdata[0 +: STATUS_W];
        got.slot_id = out_tdata[STATUS_W +: ID_W];
        got.fired   = out_tdata[STATUS_W+ID_W +: MASK_W];
        got.now     = out_tdata[STATUS_W+ID_W+MASK_W +: NOW_W];
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual %h",
                   $time, out_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          report_field("status", NOW_W'(want.status), NOW_W'(got.status));
          report_field("slot_id", NOW_W'(want.slot_id), NOW_W'(got.slot_id));
          report_field("fired_mask", NOW_W'(want.fired), NOW_W'(got.fired));
          report_field("now_count", want.now, got.now);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ test/virtual_timer_multiplexer_tb.sv @@
// Testbench top for the virtual timer multiplexer: stimulus, result sink and verdict.
module virtual_timer_multiplexer_tb;
  import vtm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1300;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_AFTER      = 400;
  localparam int HOLD_CYCLES     = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int errors;
  int pending;
  int cycles = 0;
  int requests_sent = 0;
  int gap_mode = 1;

  always #10 clk = ~clk;

  virtual_timer_multiplexer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  timer_table_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("virtual_timer_multiplexer_tb NOT OK");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send(logic [OP_W-1:0] op, logic [IVL_W-1:0] ivl, logic rep,
                      logic [SEL_W-1:0] sel);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W-IVL_W-1-SEL_W){1'b0}}, sel, rep, ivl};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  task automatic idle_sender();
    int gap;
    gap = 0;
    if (gap_mode == 1 && $urandom_range(0, 4) == 0) gap = pick_gap();
    if (gap_mode == 2 && $urandom_range(0, 1) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result sink: random stalls in phases, one long hold-off
  initial begin
    int stall_left;
    int hold_left;
    int stall_pct;
    int phase_cycles;
    bit hold_done;
    stall_left   = 0;
    hold_left    = 0;
    stall_pct    = 10;
    phase_cycles = 0;
    hold_done    = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      phase_cycles++;
      if (phase_cycles % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && requests_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int counted;
    int pick;
    logic [OP_W-1:0]  op;
    logic [IVL_W-1:0] ivl;
    logic             rep;
    logic [SEL_W-1:0] sel;
    counted = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_TICK;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, full table, equal expiries, zero and wrapping intervals
    send(OP_UNUSED, '1, 1'b1, 3'd7);        idle_sender();
    send(OP_TICK, '0, 1'b0, 3'd0);          idle_sender();
    send(OP_START, '0, 1'b0, 3'd0);         idle_sender();
    send(OP_START, '1, 1'b1, 3'd7);         idle_sender();
    send(OP_START, 32'd3, 1'b0, 3'd0);      idle_sender();
    send(OP_START, 32'd3, 1'b1, 3'd0);      idle_sender();
    send(OP_START, 32'd5, 1'b1, 3'd0);      idle_sender();
    send(OP_START, 32'd1, 1'b0, 3'd0);      idle_sender();
    send(OP_START, 32'd2, 1'b1, 3'd0);      idle_sender();
    send(OP_START, '0, 1'b1, 3'd0);         idle_sender();
    send(OP_START, 32'd4, 1'b1, 3'd0);      idle_sender();
    repeat (6) begin
      send(OP_TICK, '0, 1'b0, 3'd0);        idle_sender();
    end
    send(OP_CANCEL, '0, 1'b0, 3'd0);        idle_sender();
    send(OP_CANCEL, '0, 1'b0, 3'd1);        idle_sender();
    send(OP_CANCEL, '0, 1'b0, 3'd7);        idle_sender();
    send(OP_CANCEL, '0, 1'b0, 3'd0);        idle_sender();
    send(OP_CANCEL, '0, 1'b0, 3'd5);        idle_sender();
    send(OP_TICK, '0, 1'b0, 3'd0);          idle_sender();

    while (counted < RANDOM_REQUESTS) begin
      if (counted % 150 == 0) gap_mode = $urandom_range(0, 2);
      ivl  = $urandom;
      rep  = $urandom_range(0, 1);
      sel  = $urandom_range(0, 7);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        op = OP_TICK;
      end else if (pick < 75) begin
        op = OP_START;
        case ($urandom_range(0, 9))
          0: ivl = '0;
          1, 2: ivl = $urandom;
          default: ivl = $urandom_range(1, 40);
        endcase
      end else if (pick < 94) begin
        op = OP_CANCEL;
      end else begin
        op = OP_UNUSED;
      end
      send(op, ivl, rep, sel);
      if (op != OP_UNUSED) counted++;
      idle_sender();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("virtual_timer_multiplexer_tb OK");
    end else begin
      $display("virtual_timer_multiplexer_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ virtual_timer_multiplexer.f @@
rtl/vtm_pkg.sv
rtl/vtm_ctrl.sv
rtl/vtm_dp.sv
rtl/virtual_timer_multiplexer.sv
test/timer_table_checker.sv
test/virtual_timer_multiplexer_tb.sv
